// ===== design/i2c_master_slave_sequencer_top_assert.svh =====
// assertion macros for the sequencer checker
`ifndef I2C_MASTER_SLAVE_SEQUENCER_TOP_ASSERT_SVH
`define I2C_MASTER_SLAVE_SEQUENCER_TOP_ASSERT_SVH

// checked while out of reset
`define I2CS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sequencer assertion failed");

// checked on every edge, reset included
`define I2CS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sequencer assertion failed");

`endif

// ===== design/i2cs_pkg.sv =====
package i2cs_pkg;

    localparam int BUFFER_DEPTH_DEF = 256;
    localparam int MID_DEPTH        = 2;
    localparam int OUT_DEPTH        = 4;

    localparam logic [2:0] OP_EVENT    = 3'd0;
    localparam logic [2:0] OP_START_WR = 3'd1;
    localparam logic [2:0] OP_START_RD = 3'd2;
    localparam logic [2:0] OP_WR_RD    = 3'd3;
    localparam logic [2:0] OP_BUF_WR   = 3'd4;
    localparam logic [2:0] OP_BUF_RD   = 3'd5;

    localparam logic       REG_BUFFER_LIMIT = 1'b0;
    localparam logic [8:0] LIMIT_RESET      = 9'd256;
    localparam logic [7:0] STATUS_MASK      = 8'hF8;

    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_RSTART       = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
    localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST     = 8'h38;
    localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
    localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;
    localparam logic [7:0] ST_SR_SLA_ACK   = 8'h60;
    localparam logic [7:0] ST_SR_ARB_SLA   = 8'h68;
    localparam logic [7:0] ST_SR_GCALL     = 8'h70;
    localparam logic [7:0] ST_SR_ARB_GCALL = 8'h78;
    localparam logic [7:0] ST_SR_DATA_ACK  = 8'h80;
    localparam logic [7:0] ST_SR_DATA_NACK = 8'h88;
    localparam logic [7:0] ST_SR_GDAT_ACK  = 8'h90;
    localparam logic [7:0] ST_SR_GDAT_NACK = 8'h98;
    localparam logic [7:0] ST_SR_STOP      = 8'hA0;
    localparam logic [7:0] ST_ST_SLA_ACK   = 8'hA8;
    localparam logic [7:0] ST_ST_ARB_SLA   = 8'hB0;
    localparam logic [7:0] ST_ST_DATA_ACK  = 8'hB8;
    localparam logic [7:0] ST_ST_DATA_NACK = 8'hC0;
    localparam logic [7:0] ST_ST_LAST_ACK  = 8'hC8;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_ACK     = 3'd2,
        CMD_NACK    = 3'd3,
        CMD_SEND    = 3'd4,
        CMD_STOP    = 3'd5,
        CMD_RESTART = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        K_NOP,
        K_EVENT,
        K_START,
        K_BUF_WR,
        K_BUF_RD
    } t_kind;

    typedef enum logic [1:0] {
        XF_WRITE      = 2'd0,
        XF_READ       = 2'd1,
        XF_WRITE_READ = 2'd2
    } t_xfer;

    typedef struct packed {
        logic [2:0]  operation;
        logic [6:0]  slave_address;
        logic [15:0] write_count;
        logic [15:0] read_count;
        logic [7:0]  bus_status;
        logic [7:0]  bus_byte;
        logic [7:0]  buffer_index;
        logic [7:0]  buffer_data;
    } t_in_word;

    typedef struct packed {
        logic [2:0] bus_command;
        logic       transmit_valid;
        logic [7:0] transmit_byte;
        logic       done_res;
        logic [7:0] done_status;
        logic       busy_res;
        logic [8:0] received_length;
        logic [7:0] read_data;
    } t_out_word;

    typedef struct packed {
        t_kind      kind;
        t_xfer      xfer;
        logic [6:0] address;
        logic [8:0] send_cnt;
        logic [8:0] recv_cnt;
        logic [7:0] status;
        logic [7:0] bus_byte;
        logic [7:0] buf_index;
        logic [7:0] buf_data;
    } t_task;

    function automatic logic [8:0] eff_limit(input logic [8:0] limit, input int depth);
        if ({23'd0, limit} < depth) begin
            return limit;
        end
        return 9'(depth);
    endfunction

    function automatic logic [8:0] clamp_count(input logic [15:0] n, input logic [8:0] lim);
        if (n > {7'd0, lim}) begin
            return lim;
        end
        return n[8:0];
    endfunction

endpackage

// ===== design/i2cs_fifo.sv =====
module i2cs_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  T                           i_wdata,
    output logic                       o_full,
    input  logic                       i_pop,
    output T                           o_rdata,
    output logic                       o_empty,
    output logic [$clog2(DEPTH):0]     o_count
);
    localparam int AW = $clog2(DEPTH);

    T               r_mem [DEPTH];
    logic [AW-1:0]  r_wptr;
    logic [AW-1:0]  r_rptr;
    logic [AW:0]    r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == (AW + 1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end
endmodule

// ===== design/i2cs_front.sv =====
module i2cs_front #(
    parameter int BUFFER_DEPTH = 256
) (
    input  i2cs_pkg::t_in_word i_in,
    input  logic [8:0]         i_limit,
    output i2cs_pkg::t_task    o_task
);
    import i2cs_pkg::*;

    logic [8:0] lim;

    assign lim = eff_limit(i_limit, BUFFER_DEPTH);

    always_comb begin
        o_task           = '0;
        o_task.address   = i_in.slave_address;
        o_task.send_cnt  = clamp_count(i_in.write_count, lim);
        o_task.recv_cnt  = clamp_count(i_in.read_count, lim);
        o_task.status    = i_in.bus_status & STATUS_MASK;
        o_task.bus_byte  = i_in.bus_byte;
        o_task.buf_index = i_in.buffer_index;
        o_task.buf_data  = i_in.buffer_data;
        o_task.xfer      = XF_WRITE;
        unique case (i_in.operation)
            OP_EVENT: begin
                o_task.kind = K_EVENT;
            end
            OP_START_WR: begin
                o_task.kind = K_START;
                o_task.xfer = XF_WRITE;
            end
            OP_START_RD: begin
                o_task.kind = K_START;
                o_task.xfer = XF_READ;
            end
            OP_WR_RD: begin
                o_task.kind = K_START;
                o_task.xfer = XF_WRITE_READ;
            end
            OP_BUF_WR: begin
                o_task.kind = K_BUF_WR;
            end
            OP_BUF_RD: begin
                o_task.kind = K_BUF_RD;
            end
            default: begin
                o_task.kind = K_NOP;
            end
        endcase
    end
endmodule

// ===== design/i2cs_back.sv =====
module i2cs_back #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  i2cs_pkg::t_task      i_task,
    output logic                 o_take,
    input  logic [8:0]           i_limit,
    input  logic [$clog2(i2cs_pkg::OUT_DEPTH):0] i_out_count,
    output logic                 o_valid,
    output i2cs_pkg::t_out_word  o_word
);
    import i2cs_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(OUT_DEPTH) + 2;

    logic [7:0]  r_mem [BUFFER_DEPTH];
    logic [7:0]  r_mem_q;

    logic [8:0]  r_pos, n_pos;
    logic [8:0]  r_send, n_send;
    logic [8:0]  r_recv, n_recv;
    logic [6:0]  r_addr, n_addr;
    t_xfer       r_xfer, n_xfer;
    logic        r_phase, n_phase;
    logic        r_busy, n_busy;
    logic [8:0]  r_slen, n_slen;

    logic        r_s2_valid;
    t_out_word   r_s2;
    logic        r_tb_mem;
    logic        r_rd_mem;
    logic        r_mem_ok;

    t_out_word   res;
    logic        tb_mem;
    logic        rd_mem;
    logic        mem_ok;
    logic        mem_we;
    logic [31:0] mem_wa;
    logic [31:0] mem_ra;
    logic [7:0]  mem_wd;
    logic [8:0]  lim;
    logic [8:0]  p;

    function automatic logic fits(input logic [31:0] a);
        return a < 32'(BUFFER_DEPTH);
    endfunction

    assign lim    = eff_limit(i_limit, BUFFER_DEPTH);
    assign o_take = i_valid &&
                    ((CW'(i_out_count) + CW'(r_s2_valid)) < CW'(OUT_DEPTH));

    always_comb begin
        n_pos   = r_pos;
        n_send  = r_send;
        n_recv  = r_recv;
        n_addr  = r_addr;
        n_xfer  = r_xfer;
        n_phase = r_phase;
        n_busy  = r_busy;
        n_slen  = r_slen;
        res     = '0;
        tb_mem  = 1'b0;
        rd_mem  = 1'b0;
        mem_ok  = 1'b0;
        mem_we  = 1'b0;
        mem_wa  = {23'd0, r_pos};
        mem_wd  = i_task.bus_byte;
        mem_ra  = {23'd0, r_pos};
        p       = '0;
        res.bus_command = CMD_NONE;
        unique case (i_task.kind)
            K_START: begin
                n_busy = 1'b1;
                if (i_task.xfer != XF_READ) begin
                    n_send = i_task.send_cnt;
                end
                if (i_task.xfer != XF_WRITE) begin
                    n_recv = i_task.recv_cnt;
                end
                n_xfer  = i_task.xfer;
                n_phase = (i_task.xfer == XF_READ);
                n_addr  = i_task.address;
                res.bus_command = CMD_START;
            end
            K_BUF_WR: begin
                mem_wa = {24'd0, i_task.buf_index};
                mem_wd = i_task.buf_data;
                mem_we = fits(mem_wa);
            end
            K_BUF_RD: begin
                mem_ra = {24'd0, i_task.buf_index};
                rd_mem = 1'b1;
                mem_ok = fits(mem_ra);
            end
            K_EVENT: begin
                unique case (i_task.status)
                    ST_START, ST_RSTART: begin
                        n_pos = '0;
                        res.transmit_valid = 1'b1;
                        res.transmit_byte  = {r_addr, r_phase};
                        res.bus_command    = CMD_ACK;
                    end
                    ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
                        if (r_pos == r_send) begin
                            if (r_xfer == XF_WRITE_READ) begin
                                n_phase = 1'b1;
                                res.bus_command = CMD_START;
                            end else begin
                                res.done_res    = 1'b1;
                                res.bus_command = CMD_STOP;
                                n_busy          = 1'b0;
                            end
                        end else begin
                            res.transmit_valid = 1'b1;
                            tb_mem = 1'b1;
                            mem_ok = fits(mem_ra);
                            n_pos  = r_pos + 1'b1;
                            res.bus_command = CMD_SEND;
                        end
                    end
                    ST_MR_DATA_ACK, ST_MR_SLA_ACK: begin
                        if (i_task.status == ST_MR_DATA_ACK) begin
                            mem_we = (r_pos < lim);
                            n_pos  = r_pos + 1'b1;
                        end
                        res.bus_command = (({1'b0, n_pos} + 10'd1) == {1'b0, r_recv}) ?
                                          CMD_NACK : CMD_ACK;
                    end
                    ST_MR_DATA_NACK: begin
                        mem_we = (r_pos < lim);
                        n_pos  = r_pos + 1'b1;
                        res.done_res    = 1'b1;
                        res.bus_command = CMD_STOP;
                        n_busy          = 1'b0;
                    end
                    ST_SR_SLA_ACK, ST_SR_ARB_SLA, ST_SR_GCALL, ST_SR_ARB_GCALL: begin
                        n_pos = '0;
                        res.bus_command = CMD_ACK;
                    end
                    ST_SR_DATA_ACK, ST_SR_GDAT_ACK: begin
                        if (r_pos < lim) begin
                            mem_we = 1'b1;
                            n_pos  = r_pos + 1'b1;
                        end
                        res.bus_command = CMD_ACK;
                    end
                    ST_SR_STOP: begin
                        n_slen = r_pos;
                        res.done_res    = 1'b1;
                        res.bus_command = CMD_ACK;
                    end
                    ST_ST_SLA_ACK, ST_ST_ARB_SLA, ST_ST_DATA_ACK: begin
                        p = (i_task.status == ST_ST_DATA_ACK) ? r_pos : 9'd0;
                        mem_ra = {23'd0, p};
                        n_pos  = p;
                        if (p < lim) begin
                            res.transmit_valid = 1'b1;
                            tb_mem = 1'b1;
                            mem_ok = fits(mem_ra);
                            n_pos  = p + 1'b1;
                        end
                        res.bus_command = CMD_ACK;
                    end
                    ST_SR_DATA_NACK, ST_SR_GDAT_NACK, ST_ST_DATA_NACK, ST_ST_LAST_ACK: begin
                        res.bus_command = CMD_ACK;
                    end
                    ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_MR_SLA_NACK: begin
                        res.done_res    = 1'b1;
                        res.done_status = i_task.status;
                        res.bus_command = CMD_RESTART;
                    end
                    default: begin
                        res.bus_command = CMD_RESTART;
                    end
                endcase
            end
            default: begin
                res.bus_command = CMD_NONE;
            end
        endcase
        res.busy_res        = n_busy;
        res.received_length = n_slen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_send     <= '0;
            r_recv     <= '0;
            r_addr     <= '0;
            r_xfer     <= XF_WRITE;
            r_phase    <= 1'b0;
            r_busy     <= 1'b0;
            r_slen     <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= o_take;
            if (o_take) begin
                r_pos   <= n_pos;
                r_send  <= n_send;
                r_recv  <= n_recv;
                r_addr  <= n_addr;
                r_xfer  <= n_xfer;
                r_phase <= n_phase;
                r_busy  <= n_busy;
                r_slen  <= n_slen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_s2     <= res;
            r_tb_mem <= tb_mem;
            r_rd_mem <= rd_mem;
            r_mem_ok <= mem_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && mem_we) begin
            r_mem[mem_wa[AW-1:0]] <= mem_wd;
        end
        if (o_take) begin
            r_mem_q <= r_mem[mem_ra[AW-1:0]];
        end
    end

    always_comb begin
        o_word = r_s2;
        if (r_tb_mem) begin
            o_word.transmit_byte = r_mem_ok ? r_mem_q : 8'd0;
        end
        if (r_rd_mem) begin
            o_word.read_data = r_mem_ok ? r_mem_q : 8'd0;
        end
    end

    assign o_valid = r_s2_valid;
endmodule

// ===== design/i2c_master_slave_sequencer_top.sv =====
// Two-wire bus sequencer, master and slave. Push one word per cycle while
// o_full is low: a bus event, a master start, or a buffer access; every
// word gives exactly one result word, in order. The sustained rate is one
// word per clock while the result queue has room, set by the back stage that
// updates the transfer state and makes at most one write and one registered
// read of the byte buffer per cycle. A decode stage and a two-word queue sit
// in front of it, a four-word result queue behind it. buffer_limit sits at
// byte address 0 of the register port and resets to 256; the buffer is
// undefined until written.
module i2c_master_slave_sequencer_top #(
    parameter int BUFFER_DEPTH = i2cs_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  i2cs_pkg::t_in_word  i_in,
    output logic                o_empty,
    input  logic                i_pop,
    output i2cs_pkg::t_out_word o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import i2cs_pkg::*;

    localparam int OCW = $clog2(OUT_DEPTH) + 1;
    localparam int MCW = $clog2(MID_DEPTH) + 1;

    logic [8:0]     r_limit;
    t_task          front_task;
    t_task          mid_task;
    logic           mid_empty;
    logic           mid_take;
    logic [MCW-1:0] mid_count;
    logic           back_valid;
    t_out_word      back_word;
    logic [OCW-1:0] out_count;
    logic           out_full;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BUFFER_LIMIT) ? {23'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_BUFFER_LIMIT)) begin
            r_limit <= pwdata[8:0];
        end
    end

    i2cs_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
        .i_in    (i_in),
        .i_limit (r_limit),
        .o_task  (front_task)
    );

    i2cs_fifo #(.T(t_task), .DEPTH(MID_DEPTH)) u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata (front_task),
        .o_full  (o_full),
        .i_pop   (mid_take),
        .o_rdata (mid_task),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    i2cs_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!mid_empty && (mid_count != '0)),
        .i_task      (mid_task),
        .o_take      (mid_take),
        .i_limit     (r_limit),
        .i_out_count (out_count),
        .o_valid     (back_valid),
        .o_word      (back_word)
    );

    i2cs_fifo #(.T(t_out_word), .DEPTH(OUT_DEPTH)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_valid),
        .i_wdata (back_word),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_rdata (o_out),
        .o_empty (o_empty),
        .o_count (out_count)
    );
endmodule

// ===== design/i2cs_checker.sv =====
`include "i2c_master_slave_sequencer_top_assert.svh"

module i2cs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_empty,
    input i2cs_pkg::t_out_word o_out,
    input logic                pready
);
    `I2CS_ASSERT_ALWAYS(a_pready_high, i_clk, pready)
    `I2CS_ASSERT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n |=> o_empty)
    `I2CS_ASSERT(a_status_needs_done, i_clk, i_rst_n, (!o_empty && (o_out.done_status != 8'd0)) |-> o_out.done_res)
    `I2CS_ASSERT(a_idle_tx_zero, i_clk, i_rst_n, (!o_empty && !o_out.transmit_valid) |-> (o_out.transmit_byte == 8'd0))
endmodule

bind i2c_master_slave_sequencer_top i2cs_checker u_checker (.*);
